[rtl/kct_pkg.sv]
// Package for the keyed counter table: sizes, the request and response
// transaction structs, and the entry and token types shared by the cell chain.
// No dependencies.
`default_nettype none

package kct_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int COORD_BITS    = 8;
   localparam int KIND_BITS     = 3;
   localparam int COUNT_BITS    = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_ZERO = '0;

   typedef enum logic {
      CMD_ADD    = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef struct packed {
      command_type           command;
      logic [COORD_BITS-1:0] cell_x;
      logic [COORD_BITS-1:0] cell_y;
      logic [KIND_BITS-1:0]  item_kind;
   } req_type;

   typedef struct packed {
      logic                  success;
      logic [COUNT_BITS-1:0] count_after;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] cell_x;
      logic [COORD_BITS-1:0] cell_y;
      logic [KIND_BITS-1:0]  item_kind;
   } key_type;

   typedef struct packed {
      logic                  valid;
      key_type               key;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   // A request walking the chain. In the compaction phase (hole set) the
   // answer has already been given and the token only closes the gap.
   typedef struct packed {
      logic        active;
      logic        hole;
      command_type command;
      key_type     key;
   } token_type;

   typedef struct packed {
      logic                  valid;
      logic                  success;
      logic [COUNT_BITS-1:0] count;
   } result_type;

endpackage

`default_nettype wire

[rtl/kct_cell.sv]
// One cell of the keyed counter table: holds one entry and one token slot.
// Depends on kct_pkg.
`default_nettype none

module kct_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  kct_pkg::token_type   tok_arrive,
   input  wire                  take_down,
   input  kct_pkg::entry_type   down_entry,
   output kct_pkg::token_type   tok_pass,
   output logic                 give_up,
   output kct_pkg::entry_type   entry_out,
   output kct_pkg::result_type  res,
   output logic                 tok_active
);

   kct_pkg::token_type tok_ff;
   kct_pkg::entry_type entry_ff;
   kct_pkg::entry_type entry_in;
   logic               hit;
   logic [kct_pkg::COUNT_BITS-1:0] count_dec;

   assign hit        = entry_ff.valid && (entry_ff.key == tok_ff.key);
   assign count_dec  = entry_ff.count - kct_pkg::COUNT_ONE;
   assign give_up    = tok_ff.active && tok_ff.hole && entry_ff.valid;
   assign entry_out  = entry_ff;
   assign tok_active = tok_ff.active;

   always_comb begin
      entry_in = entry_ff;
      tok_pass = '0;
      res      = '0;
      if (take_down) begin
         // The neighbor below moves its entry up into the gap left here.
         entry_in = down_entry;
      end else if (tok_ff.active) begin
         if (tok_ff.hole) begin
            if (entry_ff.valid) begin
               entry_in.valid = 1'b0;
               tok_pass       = tok_ff;
            end
         end else if (!entry_ff.valid) begin
            // End of the occupied prefix: the key is not in the table.
            res.valid = 1'b1;
            if (tok_ff.command == kct_pkg::CMD_ADD) begin
               entry_in.valid = 1'b1;
               entry_in.key   = tok_ff.key;
               entry_in.count = kct_pkg::COUNT_ONE;
               res.success    = 1'b1;
               res.count      = kct_pkg::COUNT_ONE;
            end
         end else if (hit) begin
            res.valid = 1'b1;
            if (tok_ff.command == kct_pkg::CMD_ADD) begin
               if (entry_ff.count == kct_pkg::COUNT_MAX) begin
                  res.count = kct_pkg::COUNT_MAX;
               end else begin
                  entry_in.count = entry_ff.count + kct_pkg::COUNT_ONE;
                  res.success    = 1'b1;
                  res.count      = entry_ff.count + kct_pkg::COUNT_ONE;
               end
            end else begin
               entry_in.count = count_dec;
               res.success    = 1'b1;
               res.count      = count_dec;
               if (count_dec == kct_pkg::COUNT_ZERO) begin
                  entry_in.valid = 1'b0;
                  tok_pass       = tok_ff;
                  tok_pass.hole  = 1'b1;
               end
            end
         end else begin
            tok_pass = tok_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         entry_ff <= '0;
      end else begin
         tok_ff   <= tok_arrive;
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

[rtl/kct_chain.sv]
// Row of keyed counter table cells with neighbor links, and the merge of the
// single answer that one cell (or the chain tail) gives in a cycle.
// Depends on kct_pkg and kct_cell.
`default_nettype none

module kct_chain (
   input  wire                                  clock,
   input  wire                                  reset,
   input  kct_pkg::token_type                   launch,
   output kct_pkg::result_type                  res,
   output logic [kct_pkg::TABLE_ENTRIES-1:0]    active_map
);

   kct_pkg::token_type  pass_tok  [kct_pkg::TABLE_ENTRIES];
   kct_pkg::entry_type  entry_all [kct_pkg::TABLE_ENTRIES];
   kct_pkg::result_type cell_res  [kct_pkg::TABLE_ENTRIES];
   logic [kct_pkg::TABLE_ENTRIES-1:0] give;
   logic                tail_miss;

   for (genvar i = 0; i < kct_pkg::TABLE_ENTRIES; i++) begin : g_cell
      kct_pkg::token_type arrive;
      kct_pkg::entry_type below;
      logic               take;

      if (i == 0) begin : g_first
         assign arrive = launch;
      end else begin : g_next
         assign arrive = pass_tok[i-1];
      end

      if (i == kct_pkg::TABLE_ENTRIES - 1) begin : g_last
         assign below = '0;
         assign take  = 1'b0;
      end else begin : g_inner
         assign below = entry_all[i+1];
         assign take  = give[i+1];
      end

      kct_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_arrive (arrive),
         .take_down  (take),
         .down_entry (below),
         .tok_pass   (pass_tok[i]),
         .give_up    (give[i]),
         .entry_out  (entry_all[i]),
         .res        (cell_res[i]),
         .tok_active (active_map[i])
      );
   end

   // A searching token that runs off the end found neither its key nor a
   // free entry: a full table on add, an absent key on remove.
   assign tail_miss = pass_tok[kct_pkg::TABLE_ENTRIES-1].active &&
                      !pass_tok[kct_pkg::TABLE_ENTRIES-1].hole;

   always_comb begin
      res = '0;
      for (int i = 0; i < kct_pkg::TABLE_ENTRIES; i++) begin
         res = kct_pkg::result_type'(res | cell_res[i]);
      end
      if (tail_miss) begin
         res.valid = 1'b1;
      end
   end

endmodule

`default_nettype wire

[rtl/keyed_counter_table.sv]
// Keyed counter table: counts items per key (map column, map row, item kind)
// in a row of TABLE_ENTRIES cells. One request is in the table at a time. An
// accepted request enters the first cell and moves one cell per cycle until
// it meets the cell holding its key or the first free cell, where it is
// answered; a remove that frees its entry then keeps moving to the end of the
// occupied cells, pulling each entry up by one so that occupied cells always
// form an unbroken run from cell zero. The walk through the cells sets the
// rate: the block takes the next request only once the earlier one has left
// the cells, and a remove that frees an entry stays in the cells until the
// compaction reaches the end of the occupied cells. The answer passes through
// a one-deep holding register and then the output register, so a new
// transaction is taken while an earlier response still waits on rsp_stall. No
// clearing pass is needed after reset: every cell's valid bit clears at once.
// Depends on kct_pkg and kct_chain.
`default_nettype none

module keyed_counter_table (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  kct_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output kct_pkg::rsp_type  rsp_data
);

   kct_pkg::token_type  launch;
   kct_pkg::result_type chain_res;
   logic [kct_pkg::TABLE_ENTRIES-1:0] active_map;
   logic                chain_busy;
   logic                req_take;

   // Holding register between the chain and the output register.
   logic                slot_valid_ff;
   logic                slot_valid_in;
   kct_pkg::rsp_type    slot_ff;
   kct_pkg::rsp_type    slot_in;
   logic                slot_move;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   kct_pkg::rsp_type    rsp_ff;
   kct_pkg::rsp_type    rsp_in;

   assign chain_busy = |active_map;

   // The holding register is empty whenever a transaction is taken, and each
   // request gives exactly one answer, so it can never be overrun.
   assign req_stall = chain_busy || slot_valid_ff;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      launch                = '0;
      launch.active         = req_take;
      launch.command        = req_data.command;
      launch.key.cell_x     = req_data.cell_x;
      launch.key.cell_y     = req_data.cell_y;
      launch.key.item_kind  = req_data.item_kind;
   end

   kct_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .launch     (launch),
      .res        (chain_res),
      .active_map (active_map)
   );

   assign slot_move = slot_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      slot_in       = slot_ff;
      slot_valid_in = slot_valid_ff;
      if (chain_res.valid) begin
         slot_valid_in       = 1'b1;
         slot_in.success     = chain_res.success;
         slot_in.count_after = chain_res.count;
      end else if (slot_move) begin
         slot_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (slot_move) begin
         rsp_in       = slot_ff;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Only one request may be walking the cells at any time.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(active_map))
      else $error("more than one request in the cell chain");

   // An answer from the chain must never land on a full holding register.
   assert property (@(posedge clock) disable iff (reset)
      chain_res.valid |-> !slot_valid_ff)
      else $error("chain answer overran the holding register");

   // A taken transaction must show up in the first cell on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> active_map[0])
      else $error("accepted request did not enter the cell chain");

   // No answer appears unless a request is in the chain.
   assert property (@(posedge clock) disable iff (reset)
      chain_res.valid |-> chain_busy)
      else $error("answer produced with no request in the chain");

endmodule

`default_nettype wire
